// ===== design/hlp_pkg.sv =====
// Shared types and constants for the HCI LE advertising report parser.
// Depends on nothing; every other design file refers to it by scoped names.
package hlp_pkg;

  // Widths fixed by the packet format.
  localparam int unsigned POS_W   = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned TOTAL_W = 16;

  // HCI packet, event and subevent codes.
  localparam logic [BYTE_W-1:0] PKT_EVENT      = 8'h04;
  localparam logic [BYTE_W-1:0] EVT_LE_META    = 8'h3E;
  localparam logic [BYTE_W-1:0] SUB_ADV_REPORT = 8'h02;

  // Fixed byte positions in an event packet.
  localparam logic [POS_W-1:0] POS_TYPE     = 9'd0;
  localparam logic [POS_W-1:0] POS_EVENT    = 9'd1;
  localparam logic [POS_W-1:0] POS_PLEN     = 9'd2;
  localparam logic [POS_W-1:0] POS_SUBEVENT = 9'd3;
  localparam logic [POS_W-1:0] POS_NREPORTS = 9'd4;

  // Byte offsets inside one advertising report.
  localparam logic [POS_W-1:0] OFF_EVT_TYPE  = 9'd0;
  localparam logic [POS_W-1:0] OFF_ADDR_TYPE = 9'd1;
  localparam logic [POS_W-1:0] OFF_ADDR_LAST = 9'd7;
  localparam logic [POS_W-1:0] OFF_DATA_LEN  = 9'd8;
  localparam logic [POS_W-1:0] OFF_DATA      = 9'd9;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

  // Class of a result beat.
  typedef enum logic [1:0] {
    KIND_ADV_REPORT = 2'd0,
    KIND_LE_META    = 2'd1,
    KIND_HCI_EVENT  = 2'd2,
    KIND_NON_EVENT  = 2'd3
  } kind_t;

  // One result beat.
  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   device_address;
    logic [BYTE_W-1:0]   report_event_type;
    logic [BYTE_W-1:0]   address_type;
    logic [BYTE_W-1:0]   rssi;
    logic [BYTE_W-1:0]   data_length;
    logic [BYTE_W-1:0]   code;
    logic                code_present;
    logic [POS_W-1:0]    aux_length;
    logic [TOTAL_W-1:0]  adv_total;
    logic [TOTAL_W-1:0]  event_total;
  } result_t;

endpackage

// ===== design/hlp_in_stage.sv =====
// Input register stage of the HCI LE advertising report parser.
// Depends on hlp_pkg for the byte width.
module hlp_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hlp_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_packet_end,
  input  logic                        advance,
  output logic                        held_valid,
  output logic [hlp_pkg::BYTE_W-1:0]  held_byte,
  output logic                        held_end
);

  logic                        valid_r, valid_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  byte_r;
  logic                        end_r;
  logic                        accept;

  // A beat is taken whenever the held one is empty or moves on this cycle.
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload registers load only on an accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      end_r  <= in_packet_end;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;
  assign held_end   = end_r;

endmodule

// ===== design/hlp_parser.sv =====
// Packet walker of the HCI LE advertising report parser: parse state and totals.
// Depends on hlp_pkg for widths, codes and the result struct.
module hlp_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 260
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [hlp_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        packet_end,
  output logic                        emit,
  output hlp_pkg::result_t            result
);

  localparam logic [hlp_pkg::POS_W-1:0] MaxPos = hlp_pkg::POS_W'(MAX_PACKET_BYTES);

  logic [hlp_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  first_r, first_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  event_r, event_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  plen_r, plen_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  sub_r, sub_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  left_r, left_nxt;
  logic [hlp_pkg::POS_W-1:0]   off_r, off_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  het_r, het_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  hat_r, hat_nxt;
  logic [hlp_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [hlp_pkg::BYTE_W-1:0]  hdl_r, hdl_nxt;
  logic [hlp_pkg::TOTAL_W-1:0] rcnt_r, rcnt_nxt;
  logic [hlp_pkg::TOTAL_W-1:0] pcnt_r, pcnt_nxt;

  logic                        adv_pkt;
  logic                        report_done;
  logic [hlp_pkg::POS_W-1:0]   data_end;
  logic [hlp_pkg::POS_W-1:0]   n;
  logic                        is_event;
  logic                        is_meta;

  assign adv_pkt  = (first_r == hlp_pkg::PKT_EVENT) && (event_r == hlp_pkg::EVT_LE_META)
                    && (sub_r == hlp_pkg::SUB_ADV_REPORT);
  assign data_end = hlp_pkg::OFF_DATA + {1'b0, hdl_r};

  // Field capture and report walk for one byte.
  always_comb begin
    pos_nxt     = pos_r;
    first_nxt   = first_r;
    event_nxt   = event_r;
    plen_nxt    = plen_r;
    sub_nxt     = sub_r;
    left_nxt    = left_r;
    off_nxt     = off_r;
    het_nxt     = het_r;
    hat_nxt     = hat_r;
    addr_nxt    = addr_r;
    hdl_nxt     = hdl_r;
    rcnt_nxt    = rcnt_r;
    pcnt_nxt    = pcnt_r;
    report_done = 1'b0;

    if (pos_r < MaxPos) begin
      case (pos_r)
        hlp_pkg::POS_TYPE: begin
          first_nxt = data_byte;
          left_nxt  = '0;
          off_nxt   = '0;
          if (pcnt_r != hlp_pkg::TOTAL_MAX) begin
            pcnt_nxt = pcnt_r + 1'b1;
          end
        end
        hlp_pkg::POS_EVENT:    event_nxt = data_byte;
        hlp_pkg::POS_PLEN:     plen_nxt  = data_byte;
        hlp_pkg::POS_SUBEVENT: sub_nxt   = data_byte;
        hlp_pkg::POS_NREPORTS: begin
          left_nxt = data_byte;
          off_nxt  = '0;
        end
        default: begin
          if (adv_pkt && (left_r != '0)) begin
            off_nxt = off_r + 1'b1;
            if (off_r == hlp_pkg::OFF_EVT_TYPE) begin
              het_nxt = data_byte;
            end else if (off_r == hlp_pkg::OFF_ADDR_TYPE) begin
              hat_nxt = data_byte;
            end else if (off_r <= hlp_pkg::OFF_ADDR_LAST) begin
              addr_nxt = {data_byte, addr_r[hlp_pkg::ADDR_W-1:hlp_pkg::BYTE_W]};
            end else if (off_r == hlp_pkg::OFF_DATA_LEN) begin
              hdl_nxt = data_byte;
            end else if (off_r == data_end) begin
              // The RSSI byte closes the report.
              off_nxt     = '0;
              left_nxt    = left_r - 1'b1;
              report_done = 1'b1;
              if (rcnt_r != hlp_pkg::TOTAL_MAX) begin
                rcnt_nxt = rcnt_r + 1'b1;
              end
            end
          end
        end
      endcase
      pos_nxt = pos_r + 1'b1;
    end

    // The last byte of a packet rewinds the walk.
    n = pos_nxt;
    if (packet_end) begin
      pos_nxt  = '0;
      left_nxt = '0;
      off_nxt  = '0;
    end
  end

  // Result selection: a finished report, or the summary at the packet's end.
  always_comb begin
    is_event = (first_nxt == hlp_pkg::PKT_EVENT);
    is_meta  = is_event && (event_nxt == hlp_pkg::EVT_LE_META);
    emit     = 1'b0;
    result   = '0;
    result.adv_total   = rcnt_nxt;
    result.event_total = pcnt_nxt;
    if (report_done) begin
      emit                     = 1'b1;
      result.kind              = hlp_pkg::KIND_ADV_REPORT;
      result.device_address    = addr_nxt;
      result.report_event_type = het_nxt;
      result.address_type      = hat_nxt;
      result.rssi              = data_byte;
      result.data_length       = hdl_nxt;
    end else if (packet_end) begin
      if ((n >= 9'd3) && is_meta) begin
        if ((n < 9'd5) || (sub_nxt != hlp_pkg::SUB_ADV_REPORT)) begin
          emit        = 1'b1;
          result.kind = hlp_pkg::KIND_LE_META;
          if (n >= 9'd4) begin
            result.code         = sub_nxt;
            result.code_present = 1'b1;
          end
          result.aux_length = n - 9'd3;
        end
      end else if ((n >= 9'd2) && is_event) begin
        emit                = 1'b1;
        result.kind         = hlp_pkg::KIND_HCI_EVENT;
        result.code         = event_nxt;
        result.code_present = 1'b1;
        result.aux_length   = (n >= 9'd3) ? {1'b0, plen_nxt} : '0;
      end else begin
        emit                = 1'b1;
        result.kind         = hlp_pkg::KIND_NON_EVENT;
        result.code         = first_nxt;
        result.code_present = 1'b1;
        result.aux_length   = n;
      end
    end
  end

  // Parse state advances once per byte that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= '0;
      event_r <= '0;
      plen_r  <= '0;
      sub_r   <= '0;
      left_r  <= '0;
      off_r   <= '0;
      het_r   <= '0;
      hat_r   <= '0;
      addr_r  <= '0;
      hdl_r   <= '0;
      rcnt_r  <= '0;
      pcnt_r  <= '0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      event_r <= event_nxt;
      plen_r  <= plen_nxt;
      sub_r   <= sub_nxt;
      left_r  <= left_nxt;
      off_r   <= off_nxt;
      het_r   <= het_nxt;
      hat_r   <= hat_nxt;
      addr_r  <= addr_nxt;
      hdl_r   <= hdl_nxt;
      rcnt_r  <= rcnt_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

endmodule

// ===== design/hlp_out_stage.sv =====
// Result register of the HCI LE advertising report parser.
// Depends on hlp_pkg for the result struct.
module hlp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hlp_pkg::result_t  load_data,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output hlp_pkg::result_t  out_data
);

  logic              valid_r, valid_nxt;
  hlp_pkg::result_t  data_r;

  // The register can take a new beat when empty or when its beat leaves now.
  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/hci_le_adv_report_parser.sv =====
// HCI LE advertising report parser, top level: input register, walker, result register.
// Depends on hlp_pkg, hlp_in_stage, hlp_parser and hlp_out_stage.
//
// Feed received HCI packets one byte per beat, with in_packet_end set on each
// packet's last byte. The block takes one byte every cycle while in_stall is
// low; a byte is held in the input register, and the result beat it causes
// is loaded into the result register; the rate is set by the single pass
// through the packet walker between those two registers. For an LE Meta
// advertising report event one result comes out per report, on its RSSI byte;
// any other packet yields one summary beat at its last byte. Bytes beyond
// MAX_PACKET_BYTES are ignored, but their end flag still closes the packet.
// The report and packet totals saturate at 65535 and clear only on reset.
module hci_le_adv_report_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 260
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_packet_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [47:0]                   out_device_address,
  output logic [7:0]                    out_report_event_type,
  output logic [7:0]                    out_address_type,
  output logic signed [7:0]             out_rssi,
  output logic [7:0]                    out_data_length,
  output logic [7:0]                    out_code,
  output logic                          out_code_present,
  output logic [8:0]                    out_aux_length,
  output logic [15:0]                   out_adv_total,
  output logic [15:0]                   out_event_total
);

  logic                        advance;
  logic                        held_valid;
  logic [hlp_pkg::BYTE_W-1:0]  held_byte;
  logic                        held_end;
  logic                        fire;
  logic                        emit;
  hlp_pkg::result_t            result;
  hlp_pkg::result_t            out_data;

  hlp_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_packet_end (in_packet_end),
    .advance       (advance),
    .held_valid    (held_valid),
    .held_byte     (held_byte),
    .held_end      (held_end)
  );

  // A held byte is parsed when the result register has room for its beat.
  assign fire = held_valid && advance;

  hlp_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (held_byte),
    .packet_end (held_end),
    .emit       (emit),
    .result     (result)
  );

  hlp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .load_data (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack the result beat onto the field ports.
  assign out_kind              = out_data.kind;
  assign out_device_address    = out_data.device_address;
  assign out_report_event_type = out_data.report_event_type;
  assign out_address_type      = out_data.address_type;
  assign out_rssi              = $signed(out_data.rssi);
  assign out_data_length       = out_data.data_length;
  assign out_code              = out_data.code;
  assign out_code_present      = out_data.code_present;
  assign out_aux_length        = out_data.aux_length;
  assign out_adv_total         = out_data.adv_total;
  assign out_event_total       = out_data.event_total;

endmodule

// ===== test/hci_le_adv_report_parser_test.sv =====
// Self-checking testbench for hci_le_adv_report_parser: HCI packet bytes in, report beats out.
// Depends on hlp_pkg for the result layout, kind codes and packet constants.
`timescale 1ns / 1ps

module hci_le_adv_report_parser_test;

  localparam int unsigned MAX_BYTES = 260;
  localparam int RANDOM_BYTES = 1600;
  // Short advertising packets sent back to back at the end of the run.
  localparam int TAIL_ADV_PACKETS = 6;

  typedef struct {
    logic [7:0] data;
    logic       is_end;
    bit         drain;
  } hci_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic in_packet_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [47:0] out_device_address;
  logic [7:0] out_report_event_type;
  logic [7:0] out_address_type;
  logic signed [7:0] out_rssi;
  logic [7:0] out_data_length;
  logic [7:0] out_code;
  logic out_code_present;
  logic [8:0] out_aux_length;
  logic [15:0] out_adv_total;
  logic [15:0] out_event_total;

  hci_le_adv_report_parser #(.MAX_PACKET_BYTES(MAX_BYTES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_packet_end(in_packet_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_device_address(out_device_address),
    .out_report_event_type(out_report_event_type),
    .out_address_type(out_address_type),
    .out_rssi(out_rssi),
    .out_data_length(out_data_length),
    .out_code(out_code),
    .out_code_present(out_code_present),
    .out_aux_length(out_aux_length),
    .out_adv_total(out_adv_total),
    .out_event_total(out_event_total)
  );

  hci_beat_t pending_bytes[$];
  hlp_pkg::result_t parse_results_q[$];
  logic [7:0] pkt[$];
  int mismatch_count = 0;
  bit quiet_tail = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  hci_beat_t next_beat;
  hlp_pkg::result_t want;

  // Parser state as the stream has left it.
  logic [8:0] byte_pos = '0;
  logic [7:0] pkt_type = '0;
  logic [7:0] evt_code = '0;
  logic [7:0] plen_byte = '0;
  logic [7:0] sub_code = '0;
  logic [7:0] reports_left = '0;
  logic [8:0] report_off = '0;
  logic [7:0] held_evt_type = '0;
  logic [7:0] held_addr_type = '0;
  logic [7:0] held_data_len = '0;
  logic [47:0] addr_acc = '0;
  logic [15:0] report_total = '0;
  logic [15:0] packet_total = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Idling runs in windows: three stretches with bursts, then one without.
  function automatic bit idling_allowed();
    return !quiet_tail && ((($time / 2560) % 4) != 3);
  endfunction

  // Advances the parser state by one byte and queues the result beat it causes.
  task automatic parse_hci_byte(input logic [7:0] b, input logic is_end);
    hlp_pkg::result_t r;
    bit emit;
    bit report_done;
    int n;
    r = '0;
    emit = 1'b0;
    report_done = 1'b0;
    if (byte_pos < MAX_BYTES) begin
      case (byte_pos)
        hlp_pkg::POS_TYPE: begin
          pkt_type = b;
          reports_left = '0;
          report_off = '0;
          if (packet_total != hlp_pkg::TOTAL_MAX) packet_total = packet_total + 1'b1;
        end
        hlp_pkg::POS_EVENT: evt_code = b;
        hlp_pkg::POS_PLEN: plen_byte = b;
        hlp_pkg::POS_SUBEVENT: sub_code = b;
        hlp_pkg::POS_NREPORTS: begin
          reports_left = b;
          report_off = '0;
        end
        default: begin
          if (pkt_type == hlp_pkg::PKT_EVENT && evt_code == hlp_pkg::EVT_LE_META &&
              sub_code == hlp_pkg::SUB_ADV_REPORT && reports_left != 0) begin
            if (report_off == hlp_pkg::OFF_EVT_TYPE) held_evt_type = b;
            else if (report_off == hlp_pkg::OFF_ADDR_TYPE) held_addr_type = b;
            else if (report_off <= hlp_pkg::OFF_ADDR_LAST) addr_acc = {b, addr_acc[47:8]};
            else if (report_off == hlp_pkg::OFF_DATA_LEN) held_data_len = b;
            else if (report_off == hlp_pkg::OFF_DATA + held_data_len) report_done = 1'b1;
            if (report_done) begin
              // The RSSI byte closes the report.
              report_off = '0;
              reports_left = reports_left - 1'b1;
              if (report_total != hlp_pkg::TOTAL_MAX) report_total = report_total + 1'b1;
              emit = 1'b1;
              r.kind = hlp_pkg::KIND_ADV_REPORT;
              r.device_address = addr_acc;
              r.report_event_type = held_evt_type;
              r.address_type = held_addr_type;
              r.rssi = b;
              r.data_length = held_data_len;
            end else begin
              report_off = report_off + 1'b1;
            end
          end
        end
      endcase
      byte_pos = byte_pos + 1'b1;
    end

    // Summary beat at the end of every packet that is not an advertising report event.
    if (is_end) begin
      n = byte_pos;
      if (n >= 3 && pkt_type == hlp_pkg::PKT_EVENT && evt_code == hlp_pkg::EVT_LE_META) begin
        if (n < 5 || sub_code != hlp_pkg::SUB_ADV_REPORT) begin
          emit = 1'b1;
          r.kind = hlp_pkg::KIND_LE_META;
          if (n >= 4) begin
            r.code = sub_code;
            r.code_present = 1'b1;
          end
          r.aux_length = 9'(n - 3);
        end
      end else if (n >= 2 && pkt_type == hlp_pkg::PKT_EVENT) begin
        emit = 1'b1;
        r.kind = hlp_pkg::KIND_HCI_EVENT;
        r.code = evt_code;
        r.code_present = 1'b1;
        r.aux_length = (n >= 3) ? {1'b0, plen_byte} : 9'd0;
      end else begin
        emit = 1'b1;
        r.kind = hlp_pkg::KIND_NON_EVENT;
        r.code = pkt_type;
        r.code_present = 1'b1;
        r.aux_length = 9'(n);
      end
      byte_pos = '0;
      reports_left = '0;
      report_off = '0;
    end

    if (emit) begin
      r.adv_total = report_total;
      r.event_total = packet_total;
      parse_results_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [47:0] exp_val,
                             input logic [47:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Driver: presents queued bytes, predicts each accepted beat, idles in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) parse_hci_byte(in_data_byte, in_packet_end);
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (in_valid && idling_allowed() && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain && parse_results_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          next_beat = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_beat.data;
          in_packet_end <= next_beat.is_end;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parse_results_q.size() == 0) begin
          $display("%0t: result beat with none expected, kind %0d", $time, out_kind);
          mismatch_count++;
        end else begin
          want = parse_results_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("device_address", want.device_address, out_device_address);
          check_field("report_event_type", want.report_event_type, out_report_event_type);
          check_field("address_type", want.address_type, out_address_type);
          check_field("rssi", want.rssi, $unsigned(out_rssi));
          check_field("data_length", want.data_length, out_data_length);
          check_field("code", want.code, out_code);
          check_field("code_present", want.code_present, out_code_present);
          check_field("aux_length", want.aux_length, out_aux_length);
          check_field("adv_total", want.adv_total, out_adv_total);
          check_field("event_total", want.event_total, out_event_total);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Moves the packet being built into the byte queue, keeping the queue short.
  task automatic flush_packet(input bit drain);
    hci_beat_t beat;
    for (int i = 0; i < pkt.size(); i++) begin
      beat.data = pkt[i];
      beat.is_end = (i == pkt.size() - 1);
      beat.drain = drain && (i == 0);
      pending_bytes.push_back(beat);
    end
    pkt.delete();
    while (pending_bytes.size() > 4096) @(negedge clk);
  endtask

  task automatic put_random(input int count);
    for (int i = 0; i < count; i++) pkt.push_back(8'($urandom));
  endtask

  // Appends one report; a cut report loses its tail, at least the RSSI byte.
  task automatic add_report(input int dlen, input bit cut);
    int start;
    int keep;
    start = pkt.size();
    put_random(8);
    pkt.push_back(8'(dlen));
    put_random(dlen + 1);
    if (cut) begin
      keep = $urandom_range(start + 1, pkt.size() - 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
  endtask

  task automatic build_adv(input int declared, input int actual, input int dl_max,
                           input bit cut_last);
    pkt.push_back(hlp_pkg::PKT_EVENT);
    pkt.push_back(hlp_pkg::EVT_LE_META);
    pkt.push_back(8'h00);
    pkt.push_back(hlp_pkg::SUB_ADV_REPORT);
    pkt.push_back(8'(declared));
    for (int i = 0; i < actual; i++)
      add_report($urandom_range(0, dl_max), cut_last && (i == actual - 1));
    // The length byte is mostly right but is never trusted by the parser.
    pkt[2] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(pkt.size() - 3);
  endtask

  initial begin
    int random_bytes;
    int choice;
    int declared;
    int actual;
    bit drained;
    random_bytes = 0;
    drained = 1'b0;

    // Directed: one-byte event, all-ones non-event byte, two-byte event,
    // LE Meta without and with a subevent, and one report at the extremes.
    pkt.push_back(hlp_pkg::PKT_EVENT);
    flush_packet(1'b0);
    pkt.push_back(8'hFF);
    flush_packet(1'b0);
    pkt.push_back(hlp_pkg::PKT_EVENT);
    pkt.push_back(8'h00);
    flush_packet(1'b0);
    pkt.push_back(hlp_pkg::PKT_EVENT);
    pkt.push_back(hlp_pkg::EVT_LE_META);
    pkt.push_back(8'h00);
    flush_packet(1'b0);
    pkt.push_back(hlp_pkg::PKT_EVENT);
    pkt.push_back(hlp_pkg::EVT_LE_META);
    pkt.push_back(8'h01);
    pkt.push_back(hlp_pkg::SUB_ADV_REPORT);
    flush_packet(1'b0);
    pkt.push_back(hlp_pkg::PKT_EVENT);
    pkt.push_back(hlp_pkg::EVT_LE_META);
    pkt.push_back(8'h0C);
    pkt.push_back(hlp_pkg::SUB_ADV_REPORT);
    pkt.push_back(8'h01);
    pkt.push_back(8'hFF);
    pkt.push_back(8'h00);
    for (int i = 0; i < 6; i++) pkt.push_back((i % 2) ? 8'hFF : 8'h00);
    pkt.push_back(8'h00);
    pkt.push_back(8'h80);
    flush_packet(1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Overlong packets: a plain one and an advertising one whose last reports fall past the limit.
    pkt.push_back(8'h02);
    put_random(275);
    random_bytes += pkt.size();
    flush_packet(1'b0);
    build_adv(30, 30, 0, 1'b0);
    random_bytes += pkt.size();
    flush_packet(1'b0);

    // Random mix, weighted toward well-formed advertising report events.
    while (random_bytes < RANDOM_BYTES) begin
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
        case ($urandom_range(0, 9))
          0: declared = 0;
          8: declared = 255;
          9: declared = $urandom_range(0, 255);
          default: declared = $urandom_range(1, 4);
        endcase
        actual = (declared > 6) ? 6 : declared;
        case ($urandom_range(0, 5))
          0: actual = actual + $urandom_range(1, 2);
          1: actual = $urandom_range(0, actual);
          default: ;
        endcase
        build_adv(declared, actual, ($urandom_range(0, 7) == 0) ? 31 : 8,
                  $urandom_range(0, 4) == 0);
      end else if (choice < 60) begin
        pkt.push_back(hlp_pkg::PKT_EVENT);
        pkt.push_back(hlp_pkg::EVT_LE_META);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        put_random($urandom_range(0, 10));
      end else if (choice < 70) begin
        pkt.push_back(hlp_pkg::PKT_EVENT);
        put_random($urandom_range(1, 10));
      end else if (choice < 82) begin
        pkt.push_back(8'($urandom));
        put_random($urandom_range(0, 9));
      end else if (choice < 92) begin
        // Event packets cut before the report count.
        actual = $urandom_range(1, 4);
        pkt.push_back(hlp_pkg::PKT_EVENT);
        if (actual > 1) begin
          pkt.push_back(($urandom_range(0, 3) != 0) ? hlp_pkg::EVT_LE_META : 8'($urandom));
        end
        if (actual > 2) pkt.push_back(8'($urandom));
        if (actual > 3) begin
          pkt.push_back(($urandom_range(0, 1) != 0) ? hlp_pkg::SUB_ADV_REPORT : 8'($urandom));
        end
      end else begin
        put_random($urandom_range(1, 24));
      end
      random_bytes += pkt.size();
      // Halfway through, hold the sender until every result is in.
      flush_packet(!drained && random_bytes > RANDOM_BYTES / 2);
      if (random_bytes > RANDOM_BYTES / 2) drained = 1'b1;
    end

    // Back-to-back tail with no idling from here to the end.
    while (pending_bytes.size() != 0) @(negedge clk);
    quiet_tail = 1'b1;
    repeat (TAIL_ADV_PACKETS) begin
      build_adv(2, 2, 8, 1'b0);
      flush_packet(1'b0);
    end
    pkt.push_back(hlp_pkg::PKT_EVENT);
    pkt.push_back(8'h0E);
    pkt.push_back(8'h04);
    flush_packet(1'b0);

    // Let the last beats drain, then allow for the pipeline depth.
    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (parse_results_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== hci_le_adv_report_parser.f =====
design/hlp_pkg.sv
design/hlp_in_stage.sv
design/hlp_parser.sv
design/hlp_out_stage.sv
design/hci_le_adv_report_parser.sv
test/hci_le_adv_report_parser_test.sv
